FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sprite quad vertex generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPQV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQV_ASSERT(lbl, prop, msg)
`define SPQV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/spqv_pkg.sv
// Shared constants and types of the sprite quad vertex generator.
package spqv_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  localparam int VP_W       = 14;
  localparam int SCALE_W    = 17;
  localparam int SIN_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 4;

  localparam logic [VP_W-1:0] VP_WIDTH_RST  = 14'd1024;
  localparam logic [VP_W-1:0] VP_HEIGHT_RST = 14'd768;

  localparam logic [SCALE_W-1:0] SCALE_ONE   = 17'h10000;
  localparam logic [SCALE_W-1:0] SCALE_X_RST = 17'((768 * 65536) / 1024);
  localparam logic [SCALE_W-1:0] SCALE_Y_RST = 17'h10000;

  localparam int ONE_Q12 = 4096;

  localparam logic [14:0] SIN_T_FULL = 15'd16384;
  localparam logic [14:0] SIN_C0     = 15'd25736;
  localparam logic [13:0] SIN_C1     = 14'd10512;
  localparam logic [10:0] SIN_C2     = 11'd1160;

  localparam logic REG_VP_WIDTH  = 1'b0;
  localparam logic REG_VP_HEIGHT = 1'b1;

  localparam logic [1:0] ANCHOR_NEAR    = 2'd0;
  localparam logic [1:0] ANCHOR_CENTER  = 2'd1;
  localparam logic [1:0] ANCHOR_FAR     = 2'd2;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_1     = 2'd1;
  localparam logic [1:0] CORNER_2     = 2'd2;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  typedef struct packed {
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
  } scale_pair_t;

endpackage

FILE: rtl/core/spqv_cfg.sv
// Viewport registers, APB access and iterative aspect scale divider.
module spqv_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [spqv_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [spqv_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [spqv_pkg::CFG_DATA_W-1:0]     prdata,
  output spqv_pkg::scale_pair_t               scale,
  output logic                                busy
);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN} state_t;

  state_t                              state_r;
  logic [spqv_pkg::VP_W-1:0]           vw_r, vh_r, long_r, rem_r;
  logic [15:0]                         q_r;
  logic [3:0]                          cnt_r;
  logic                                side_r;
  logic [spqv_pkg::SCALE_W-1:0]        sx_r, sy_r;

  logic                                wr;
  logic [spqv_pkg::VP_W-1:0]           vw, vh;
  logic [spqv_pkg::VP_W:0]             rem2;
  logic                                ge;
  logic [spqv_pkg::VP_W-1:0]           rem_nxt;
  logic [15:0]                         q_nxt;

  assign wr      = psel && penable && pwrite;
  assign vw      = (vw_r == '0) ? spqv_pkg::VP_W'(1) : vw_r;
  assign vh      = (vh_r == '0) ? spqv_pkg::VP_W'(1) : vh_r;
  assign rem2    = {rem_r, 1'b0};
  assign ge      = rem2 >= {1'b0, long_r};
  assign rem_nxt = ge ? spqv_pkg::VP_W'(rem2 - {1'b0, long_r}) : rem2[spqv_pkg::VP_W-1:0];
  assign q_nxt   = {q_r[14:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vw_r    <= spqv_pkg::VP_WIDTH_RST;
      vh_r    <= spqv_pkg::VP_HEIGHT_RST;
      sx_r    <= spqv_pkg::SCALE_X_RST;
      sy_r    <= spqv_pkg::SCALE_Y_RST;
    end else if (wr) begin
      case (paddr[2])
        spqv_pkg::REG_VP_WIDTH:  vw_r <= pwdata[spqv_pkg::VP_W-1:0];
        spqv_pkg::REG_VP_HEIGHT: vh_r <= pwdata[spqv_pkg::VP_W-1:0];
        default: ;
      endcase
      state_r <= ST_LOAD;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (vw == vh) begin
            sx_r    <= spqv_pkg::SCALE_ONE;
            sy_r    <= spqv_pkg::SCALE_ONE;
            state_r <= ST_IDLE;
          end else begin
            side_r  <= vw < vh;
            rem_r   <= (vw < vh) ? vw : vh;
            long_r  <= (vw < vh) ? vh : vw;
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            sx_r    <= side_r ? spqv_pkg::SCALE_ONE : {1'b0, q_nxt};
            sy_r    <= side_r ? {1'b0, q_nxt} : spqv_pkg::SCALE_ONE;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign prdata   = paddr[2] ? spqv_pkg::CFG_DATA_W'(vh_r) : spqv_pkg::CFG_DATA_W'(vw_r);
  assign scale.sx = sx_r;
  assign scale.sy = sy_r;
  assign busy     = state_r != ST_IDLE;

endmodule

FILE: rtl/core/spqv_front.sv
// Front pipeline: sine and cosine of the angle, anchored centres per sprite.
module spqv_front #(
  parameter int COORD_WIDTH = spqv_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = spqv_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          busy,
  input  logic [1:0]                    x_anchor,
  input  logic [1:0]                    y_anchor,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] half_width,
  input  logic signed [COORD_WIDTH-1:0] half_height,
  input  logic [ANGLE_WIDTH-1:0]        angle,
  input  spqv_pkg::scale_pair_t         scale,
  input  logic                          fifo_full,
  output logic                          push,
  output logic signed [COORD_WIDTH+2:0] cx,
  output logic signed [COORD_WIDTH+2:0] cy,
  output logic signed [15:0]            sn,
  output logic signed [15:0]            cs,
  output logic signed [COORD_WIDTH-1:0] hw,
  output logic signed [COORD_WIDTH-1:0] hh
);

  localparam int CW    = COORD_WIDTH;
  localparam int CTR_W = CW + 3;
  localparam int PS_W  = CW + 18;

  function automatic logic signed [CTR_W-1:0] place(input logic [1:0] anc,
                                                    input logic signed [PS_W-1:0] p);
    logic signed [PS_W-1:0]  r;
    logic signed [CTR_W-1:0] q, one;
    r   = p + PS_W'(32768);
    q   = CTR_W'(r >>> 16);
    one = CTR_W'(spqv_pkg::ONE_Q12);
    case (anc)
      spqv_pkg::ANCHOR_NEAR:   place = q - one;
      spqv_pkg::ANCHOR_CENTER: place = q;
      spqv_pkg::ANCHOR_FAR:    place = one - q;
      default:                 place = '0;
    endcase
  endfunction

  logic [4:0] vld_r;
  logic       en, take;

  logic [23:0] ang24;
  logic [15:0] ph [2];
  logic [14:0] t0 [2];

  // index 0 sine, 1 cosine
  logic [1:0]              xa1_r, ya1_r, xa2_r, ya2_r;
  logic signed [CW-1:0]    px1_r, py1_r;
  logic signed [CW-1:0]    hw1_r, hh1_r, hw2_r, hh2_r, hw3_r, hh3_r, hw4_r, hh4_r;
  logic [14:0]             t1_r [2], t2_r [2], t3_r [2], t4_r [2];
  logic                    ng1_r [2], ng2_r [2], ng3_r [2], ng4_r [2];
  logic [14:0]             sq2_r [2], sq3_r [2];
  logic [13:0]             inner3_r [2];
  logic [14:0]             mid4_r [2];
  logic signed [PS_W-1:0]  psx2_r, psy2_r;
  logic signed [CTR_W-1:0] cx3_r, cy3_r, cx4_r, cy4_r, cx5_r, cy5_r;
  logic signed [15:0]      s5_r [2];
  logic signed [CW-1:0]    hw5_r, hh5_r;

  logic [29:0] sq [2];
  logic [25:0] k1 [2];
  logic [28:0] k2 [2];
  logic [29:0] k3 [2];

  assign en       = !(vld_r[4] && fifo_full);
  assign in_ready = en && !busy;
  assign take     = in_valid && in_ready;
  assign push     = vld_r[4] && !fifo_full;

  assign ang24 = 24'(angle) << (24 - ANGLE_WIDTH);
  assign ph[0] = ang24[23:8];
  assign ph[1] = ang24[23:8] + 16'd16384;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      t0[i] = ph[i][14] ? spqv_pkg::SIN_T_FULL - {1'b0, ph[i][13:0]} : {1'b0, ph[i][13:0]};
      sq[i] = t1_r[i] * t1_r[i];
      k1[i] = sq2_r[i] * spqv_pkg::SIN_C2;
      k2[i] = inner3_r[i] * sq3_r[i];
      k3[i] = t4_r[i] * mid4_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa1_r <= x_anchor;
      ya1_r <= y_anchor;
      px1_r <= pos_x;
      py1_r <= pos_y;
      hw1_r <= half_width;
      hh1_r <= half_height;
      xa2_r <= xa1_r;
      ya2_r <= ya1_r;
      hw2_r <= hw1_r;
      hh2_r <= hh1_r;
      psx2_r <= px1_r * $signed({1'b0, scale.sx});
      psy2_r <= py1_r * $signed({1'b0, scale.sy});
      hw3_r <= hw2_r;
      hh3_r <= hh2_r;
      cx3_r <= place(xa2_r, psx2_r);
      cy3_r <= place(ya2_r, psy2_r);
      hw4_r <= hw3_r;
      hh4_r <= hh3_r;
      cx4_r <= cx3_r;
      cy4_r <= cy3_r;
      hw5_r <= hw4_r;
      hh5_r <= hh4_r;
      cx5_r <= cx4_r;
      cy5_r <= cy4_r;
      for (int i = 0; i < 2; i++) begin
        t1_r[i]     <= t0[i];
        ng1_r[i]    <= ph[i][15];
        t2_r[i]     <= t1_r[i];
        ng2_r[i]    <= ng1_r[i];
        sq2_r[i]    <= sq[i][28:14];
        t3_r[i]     <= t2_r[i];
        ng3_r[i]    <= ng2_r[i];
        sq3_r[i]    <= sq2_r[i];
        inner3_r[i] <= spqv_pkg::SIN_C1 - 14'(k1[i][25:14]);
        t4_r[i]     <= t3_r[i];
        ng4_r[i]    <= ng3_r[i];
        mid4_r[i]   <= spqv_pkg::SIN_C0 - k2[i][28:14];
        s5_r[i]     <= ng4_r[i] ? -$signed(k3[i][29:14]) : $signed(k3[i][29:14]);
      end
    end
  end

  assign cx = cx5_r;
  assign cy = cy5_r;
  assign sn = s5_r[0];
  assign cs = s5_r[1];
  assign hw = hw5_r;
  assign hh = hh5_r;

endmodule

FILE: rtl/core/spqv_fifo.sv
// Short register queue between the front and back pipelines.
module spqv_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int DEPTH = spqv_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;

  assign full  = cnt_r == (PW+1)'(DEPTH);
  assign valid = cnt_r != '0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

FILE: rtl/core/spqv_back.sv
// Back pipeline: per-corner rotation, aspect scaling, saturation and output register.
`include "assert_macros.svh"
module spqv_back #(
  parameter int COORD_WIDTH = spqv_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          pop,
  input  logic signed [COORD_WIDTH+2:0] cx,
  input  logic signed [COORD_WIDTH+2:0] cy,
  input  logic signed [15:0]            sn,
  input  logic signed [15:0]            cs,
  input  logic signed [COORD_WIDTH-1:0] hw,
  input  logic signed [COORD_WIDTH-1:0] hh,
  input  spqv_pkg::scale_pair_t         scale,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] vertex_x,
  output logic signed [COORD_WIDTH-1:0] vertex_y,
  output logic                          tex_u,
  output logic                          tex_v,
  output logic [1:0]                    corner,
  output logic                          last
);

  localparam int CW    = COORD_WIDTH;
  localparam int CTR_W = CW + 3;
  localparam int P_W   = CW + 17;
  localparam int S_W   = CW + 18;
  localparam int R_W   = CW + 4;
  localparam int M_W   = CW + 22;
  localparam int V_W   = CW + 7;

  function automatic logic signed [CW-1:0] finish(input logic signed [CTR_W-1:0] c,
                                                  input logic signed [M_W-1:0] m);
    logic signed [M_W-1:0] r;
    logic signed [V_W-1:0] v;
    r = m + M_W'(32768);
    v = V_W'(c) + V_W'(r >>> 16);
    if (v[V_W-1:CW-1] == '0 || v[V_W-1:CW-1] == '1)
      finish = v[CW-1:0];
    else
      finish = v[V_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  logic                    en, step;
  logic [1:0]              cnt_r;
  logic [1:0]              vld_r;
  logic                    o_vld_r;

  logic signed [CW:0]      dx, dy;
  logic signed [P_W-1:0]   pcx1_r, psy1_r, psx1_r, pcy1_r;
  logic signed [CTR_W-1:0] cx1_r, cy1_r, cx2_r, cy2_r;
  logic [1:0]              k1_r, k2_r;
  logic signed [S_W-1:0]   sum_x, sum_y;
  logic signed [R_W-1:0]   rx, ry;
  logic signed [M_W-1:0]   mx2_r, my2_r;

  logic signed [CW-1:0]    o_vx_r, o_vy_r;
  logic [1:0]              o_k_r;

  assign en   = !o_vld_r || out_ready;
  assign step = en && q_valid;
  assign pop  = step && cnt_r == spqv_pkg::CORNER_LAST;

  assign dx = (cnt_r == spqv_pkg::CORNER_1 || cnt_r == spqv_pkg::CORNER_2) ?
              (CW+1)'(hw) : -(CW+1)'(hw);
  assign dy = cnt_r[1] ? (CW+1)'(hh) : -(CW+1)'(hh);

  assign sum_x = S_W'(pcx1_r) - S_W'(psy1_r) + S_W'(8192);
  assign sum_y = S_W'(psx1_r) + S_W'(pcy1_r) + S_W'(8192);
  assign rx    = R_W'(sum_x >>> 14);
  assign ry    = R_W'(sum_y >>> 14);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= spqv_pkg::CORNER_FIRST;
      vld_r   <= '0;
      o_vld_r <= 1'b0;
    end else if (en) begin
      if (q_valid) cnt_r <= cnt_r + 2'd1;
      vld_r   <= {vld_r[0], q_valid};
      o_vld_r <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcx1_r <= cs * dx;
      psy1_r <= sn * dy;
      psx1_r <= sn * dx;
      pcy1_r <= cs * dy;
      cx1_r  <= cx;
      cy1_r  <= cy;
      k1_r   <= cnt_r;
      mx2_r  <= rx * $signed({1'b0, scale.sx});
      my2_r  <= ry * $signed({1'b0, scale.sy});
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      k2_r   <= k1_r;
      o_vx_r <= finish(cx2_r, mx2_r);
      o_vy_r <= finish(cy2_r, my2_r);
      o_k_r  <= k2_r;
    end
  end

  assign out_valid = o_vld_r;
  assign vertex_x  = o_vx_r;
  assign vertex_y  = o_vy_r;
  assign corner    = o_k_r;
  assign tex_u     = o_k_r == spqv_pkg::CORNER_1 || o_k_r == spqv_pkg::CORNER_2;
  assign tex_v     = o_k_r == spqv_pkg::CORNER_FIRST || o_k_r == spqv_pkg::CORNER_1;
  assign last      = o_k_r == spqv_pkg::CORNER_LAST;

  `SPQV_ASSERT(a_pop_needs_job, pop |-> q_valid, "queue popped while empty")
  `SPQV_ASSERT(a_cnt_hold, !step |=> $stable(cnt_r), "corner count moved without a job")
  `SPQV_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(o_k_r)),
               "stalled vertex changed")
  `SPQV_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "output valid after reset")

endmodule

FILE: rtl/core/sprite_quad_vertex_generator_unit.sv
// Top level of the sprite quad vertex generator.
// Usage:
//   in_*  : one sprite request per transaction (anchors, position, half sizes, angle).
//   out_* : four vertex transactions per sprite, in order around the quad; out_tlast marks the fourth.
//   APB   : viewport width at byte address 0, height at 4; writes only while idle.
// Throughput: the back pipeline emits one corner per cycle while out_tready allows;
//   the front pipeline takes one request per cycle, unless a full queue or a busy
//   divider stalls it, into a four-entry queue, so short bursts are absorbed.
// After a viewport write in_tready stays low while the aspect divider runs.
// Reset (synchronous, rst_n low) clears all valids and loads 1024 x 768 with its
//   aspect scale precomputed; no clearing pass is needed.
// When out_tready is low the output register holds, the back pipeline stops,
//   the queue fills and in_tready then falls.
module sprite_quad_vertex_generator_unit #(
  parameter int COORD_WIDTH = spqv_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = spqv_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // x_anchor, y_anchor, pos_x, pos_y, half_width, half_height, angle
  input  logic [((4+4*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // vertex_x, vertex_y, tex_u, tex_v, corner
  output logic [((2*COORD_WIDTH+4+7)/8)*8-1:0] out_tdata,
  output logic                                 out_tlast,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [spqv_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [spqv_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [spqv_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int CW      = COORD_WIDTH;
  localparam int OUT_TW  = ((2*CW+4+7)/8)*8;
  localparam int CTR_W   = CW + 3;
  localparam int JOB_W   = 2*CTR_W + 32 + 2*CW;

  spqv_pkg::scale_pair_t scale;
  logic                  busy;

  logic                  push, full, pop, q_valid;
  logic signed [CTR_W-1:0] f_cx, f_cy, b_cx, b_cy;
  logic signed [15:0]    f_sn, f_cs, b_sn, b_cs;
  logic signed [CW-1:0]  f_hw, f_hh, b_hw, b_hh;
  logic [JOB_W-1:0]      wjob, rjob;

  logic signed [CW-1:0]  vx, vy;
  logic                  tu, tv;
  logic [1:0]            k;

  assign pready = 1'b1;

  spqv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .scale   (scale),
    .busy    (busy)
  );

  spqv_front #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .busy        (busy),
    .x_anchor    (in_tdata[1:0]),
    .y_anchor    (in_tdata[3:2]),
    .pos_x       ($signed(in_tdata[4 +: CW])),
    .pos_y       ($signed(in_tdata[4+CW +: CW])),
    .half_width  ($signed(in_tdata[4+2*CW +: CW])),
    .half_height ($signed(in_tdata[4+3*CW +: CW])),
    .angle       (in_tdata[4+4*CW +: ANGLE_WIDTH]),
    .scale       (scale),
    .fifo_full   (full),
    .push        (push),
    .cx          (f_cx),
    .cy          (f_cy),
    .sn          (f_sn),
    .cs          (f_cs),
    .hw          (f_hw),
    .hh          (f_hh)
  );

  assign wjob = {f_hh, f_hw, f_cs, f_sn, f_cy, f_cx};
  assign {b_hh, b_hw, b_cs, b_sn, b_cy, b_cx} = rjob;

  spqv_fifo #(.WIDTH(JOB_W)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wjob),
    .full  (full),
    .pop   (pop),
    .valid (q_valid),
    .rdata (rjob)
  );

  spqv_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .pop       (pop),
    .cx        (b_cx),
    .cy        (b_cy),
    .sn        (b_sn),
    .cs        (b_cs),
    .hw        (b_hw),
    .hh        (b_hh),
    .scale     (scale),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .vertex_x  (vx),
    .vertex_y  (vy),
    .tex_u     (tu),
    .tex_v     (tv),
    .corner    (k),
    .last      (out_tlast)
  );

  assign out_tdata = OUT_TW'({k, tv, tu, vy, vx});

endmodule

FILE: tb/sv/tb_sprite_quad_vertex_generator_unit.sv
// Testbench for the sprite quad vertex generator: directed and random sprites checked against a predictor.
`timescale 1ns / 1ps

module tb_sprite_quad_vertex_generator_unit;

  localparam int CW = 16;
  localparam int AW = 16;
  localparam int IN_W = ((4 + 4 * CW + AW + 7) / 8) * 8;
  localparam int OUT_W = ((2 * CW + 4 + 7) / 8) * 8;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 40;

  localparam logic [1:0] ANCHOR_NONE = 2'd3;
  localparam logic [spqv_pkg::CFG_ADDR_W-1:0] ADDR_VP_WIDTH  = spqv_pkg::CFG_ADDR_W'(0);
  localparam logic [spqv_pkg::CFG_ADDR_W-1:0] ADDR_VP_HEIGHT = spqv_pkg::CFG_ADDR_W'(4);

  typedef struct {
    logic [15:0] vx;
    logic [15:0] vy;
    logic        tu;
    logic        tv;
    logic [1:0]  corner;
    logic        last;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // x_anchor, y_anchor, pos_x, pos_y, half_width, half_height, angle
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // vertex_x, vertex_y, tex_u, tex_v, corner
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic psel, penable, pwrite;
  logic [spqv_pkg::CFG_ADDR_W-1:0] paddr;
  logic [spqv_pkg::CFG_DATA_W-1:0] pwdata;
  logic [spqv_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  vertex_t expected_vertices[$];
  logic [13:0] vp_w, vp_h;
  int errors;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  sprite_quad_vertex_generator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint quarter_wave(longint t);
    longint t2, inner, mid;
    t2 = (t * t) >> 14;
    inner = 10512 - ((1160 * t2) >> 14);
    mid = 25736 - ((inner * t2) >> 14);
    return (t * mid) >> 14;
  endfunction

  function automatic longint sine_of(logic [15:0] ph);
    longint t, s;
    t = ph[13:0];
    s = ph[14] ? quarter_wave(16384 - t) : quarter_wave(t);
    return ph[15] ? -s : s;
  endfunction

  function automatic longint anchor_centre(logic [1:0] a, longint p, longint s);
    longint ps;
    ps = round_shift(p * s, 16);
    case (a)
      spqv_pkg::ANCHOR_NEAR:   return ps - spqv_pkg::ONE_Q12;
      spqv_pkg::ANCHOR_CENTER: return ps;
      spqv_pkg::ANCHOR_FAR:    return spqv_pkg::ONE_Q12 - ps;
      default:                 return 0;
    endcase
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  task automatic predict_quad(logic [IN_W-1:0] d);
    longint w, h, sx, sy, px, py, hw, hh, sn, cs, cx, cy, dx, dy, rx, ry;
    logic [15:0] ang;
    vertex_t v;
    w = (vp_w == 0) ? 1 : vp_w;
    h = (vp_h == 0) ? 1 : vp_h;
    sx = 65536;
    sy = 65536;
    if (w < h) sy = (w << 16) / h;
    else sx = (h << 16) / w;
    px = $signed(d[19:4]);
    py = $signed(d[35:20]);
    hw = $signed(d[51:36]);
    hh = $signed(d[67:52]);
    ang = d[83:68];
    sn = sine_of(ang);
    cs = sine_of(ang + 16'd16384);
    cx = anchor_centre(d[1:0], px, sx);
    cy = anchor_centre(d[3:2], py, sy);
    for (int k = 0; k < 4; k++) begin
      dx = (k == 0 || k == 3) ? -hw : hw;
      dy = (k < 2) ? -hh : hh;
      rx = round_shift(cs * dx - sn * dy, 14);
      ry = round_shift(sn * dx + cs * dy, 14);
      v.vx = clamp16(cx + round_shift(rx * sx, 16));
      v.vy = clamp16(cy + round_shift(ry * sy, 16));
      v.tu = (k == 1 || k == 2);
      v.tv = (k < 2);
      v.corner = k[1:0];
      v.last = (k == 3);
      expected_vertices.push_back(v);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected vertex", out_tdata, 0);
      end else begin
        vertex_t e;
        e = expected_vertices.pop_front();
        if (out_tdata[15:0] !== e.vx) report_mismatch("vertex_x", out_tdata[15:0], e.vx);
        if (out_tdata[31:16] !== e.vy) report_mismatch("vertex_y", out_tdata[31:16], e.vy);
        if (out_tdata[32] !== e.tu) report_mismatch("tex_u", out_tdata[32], e.tu);
        if (out_tdata[33] !== e.tv) report_mismatch("tex_v", out_tdata[33], e.tv);
        if (out_tdata[35:34] !== e.corner)
          report_mismatch("corner", out_tdata[35:34], e.corner);
        if (out_tlast !== e.last) report_mismatch("tlast", out_tlast, e.last);
      end
    end
  end

  task automatic send_sprite(logic [1:0] xa, logic [1:0] ya, logic [15:0] px,
                             logic [15:0] py, logic [15:0] hw, logic [15:0] hh,
                             logic [15:0] ang);
    logic [IN_W-1:0] d;
    d = '0;
    d[83:0] = {ang, hh, hw, py, px, ya, xa};
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_quad(d);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_viewport(logic [spqv_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_VP_WIDTH) vp_w = val[13:0];
    else vp_h = val[13:0];
    @(posedge clk);
  endtask

  task automatic set_viewport(logic [31:0] w, logic [31:0] h);
    wait_drained();
    write_viewport(ADDR_VP_WIDTH, w);
    write_viewport(ADDR_VP_HEIGHT, h);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_random(int n);
    logic [15:0] hw, hh;
    for (int i = 0; i < n; i++) begin
      hw = 16'($urandom());
      hh = 16'($urandom());
      if ($urandom_range(3) != 0) begin
        hw = 16'($urandom_range(8191));
        hh = 16'($urandom_range(8191));
      end
      send_sprite(2'($urandom()), 2'($urandom()), 16'($urandom()), 16'($urandom()),
                  hw, hh, 16'($urandom()));
    end
  endtask

  task automatic test_directed();
    send_sprite(spqv_pkg::ANCHOR_NEAR, spqv_pkg::ANCHOR_NEAR, 16'd0, 16'd0,
                16'd4096, 16'd4096, 16'd0);
    send_sprite(spqv_pkg::ANCHOR_CENTER, spqv_pkg::ANCHOR_CENTER, 16'h7fff, 16'h8000,
                16'd2048, 16'd1024, 16'h4000);
    send_sprite(spqv_pkg::ANCHOR_FAR, spqv_pkg::ANCHOR_FAR, 16'h8000, 16'h7fff,
                16'h7fff, 16'h7fff, 16'h8000);
    send_sprite(ANCHOR_NONE, ANCHOR_NONE, 16'h1234, 16'h4321, 16'h8000, 16'h8000, 16'hc000);
    send_sprite(ANCHOR_NONE, spqv_pkg::ANCHOR_CENTER, 16'h7fff, 16'h7fff, 16'h7fff,
                16'h8000, 16'hffff);
    send_sprite(spqv_pkg::ANCHOR_CENTER, ANCHOR_NONE, 16'hffff, 16'h0001, 16'd0, 16'd0,
                16'h2000);
    send_sprite(spqv_pkg::ANCHOR_NEAR, spqv_pkg::ANCHOR_FAR, 16'h8000, 16'h8000, 16'h8000,
                16'h7fff, 16'h0001);
    send_sprite(spqv_pkg::ANCHOR_FAR, spqv_pkg::ANCHOR_NEAR, 16'h0800, 16'hf800, 16'h0400,
                16'h0c00, 16'h6000);
  endtask

  task automatic test_viewports();
    set_viewport(0, 0);
    send_sprite(spqv_pkg::ANCHOR_CENTER, spqv_pkg::ANCHOR_CENTER, 16'h1000, 16'h1000,
                16'h0800, 16'h0800, 16'h1000);
    set_viewport(8192, 1);
    send_random(10);
    set_viewport(1, 8192);
    send_random(10);
    set_viewport(16383, 16383);
    send_random(10);
    set_viewport(32'hffff_c123, 600);
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(60);
    send_idle_pct = 49; recv_stall_pct = 0;  send_random(60);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 49; send_random(55);
    set_viewport($urandom_range(1, 8192), $urandom_range(1, 8192));
    send_idle_pct = 21; recv_stall_pct = 21; send_random(55);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    vp_w = 14'd1024;
    vp_h = 14'd768;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_viewports();
    test_random_phases();
    wait_drained();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
